// ===== design/fjd_pkg.sv =====
package fjd_pkg;

  localparam int MAX_W    = 24;
  localparam int FRAMES_W = 32;

  localparam logic [7:0]       MARK_FF   = 8'hFF;
  localparam logic [7:0]       MARK_SOI  = 8'hD8;
  localparam logic [7:0]       MARK_EOI  = 8'hD9;
  localparam logic [MAX_W-1:0] MAX_RESET = 24'd1048576;

  typedef enum logic [1:0] {
    CMD_SOI,
    CMD_DATA,
    CMD_EOI,
    CMD_ABORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [7:0]            data;
    logic [FRAMES_W-1:0]   frames;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    FR_HUNT,
    FR_FRAME
  } front_state_t;

  typedef enum logic {
    BK_FIRST,
    BK_SECOND
  } back_state_t;

endpackage

// ===== design/fjd_fifo.sv =====
module fjd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  fjd_pkg::cmd_t   wr_data,
  input  logic            rd_en,
  output fjd_pkg::cmd_t   rd_data,
  output fjd_pkg::q_stat_t stat
);
  import fjd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not advance on write");

endmodule

// ===== design/fjd_front.sv =====
module fjd_front #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fjd_pkg::MAX_W-1:0]     cfg_wdata,
  input  logic                          push,
  input  logic [7:0]                    in_byte,
  input  logic                          q_full,
  output logic                          cmd_push,
  output fjd_pkg::cmd_t                 cmd
);
  import fjd_pkg::*;

  localparam int CMP_W = (LENGTH_BITS + 1 > MAX_W) ? LENGTH_BITS + 1 : MAX_W;

  front_state_t           state_r, state_nxt;
  logic [MAX_W-1:0]       max_r;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   prev_ff_r, prev_ff_nxt;
  logic [FRAMES_W-1:0]    cnt_r, cnt_nxt;
  logic [LENGTH_BITS:0]   len_inc;
  logic                   accept, is_ff, soi_hit, eoi_hit, ovf;

  assign accept  = push && !q_full;
  assign is_ff   = (in_byte == MARK_FF);
  assign soi_hit = prev_ff_r && (in_byte == MARK_SOI);
  assign eoi_hit = prev_ff_r && (in_byte == MARK_EOI);
  assign len_inc = {1'b0, len_r} + 1'b1;
  assign ovf     = len_inc[LENGTH_BITS] || (CMP_W'(len_inc) > CMP_W'(max_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_HUNT: begin
        if (accept && soi_hit) begin
          state_nxt = FR_FRAME;
        end
      end
      FR_FRAME: begin
        if (accept && (ovf || eoi_hit)) begin
          state_nxt = FR_HUNT;
        end
      end
      default: state_nxt = FR_HUNT;
    endcase
  end

  always_comb begin
    len_nxt     = len_r;
    prev_ff_nxt = prev_ff_r;
    cnt_nxt     = cnt_r;
    cmd_push    = 1'b0;
    cmd.kind    = CMD_DATA;
    cmd.data    = in_byte;
    cmd.frames  = cnt_r;
    case (state_r)
      FR_HUNT: begin
        if (accept) begin
          if (soi_hit) begin
            cmd_push    = 1'b1;
            cmd.kind    = CMD_SOI;
            len_nxt     = LENGTH_BITS'(2);
            prev_ff_nxt = 1'b0;
          end else begin
            prev_ff_nxt = is_ff;
          end
        end
      end
      FR_FRAME: begin
        if (accept) begin
          cmd_push = 1'b1;
          if (ovf) begin
            // drop the oversize frame
            cmd.kind    = CMD_ABORT;
            cmd.data    = '0;
            len_nxt     = '0;
            prev_ff_nxt = 1'b0;
          end else if (eoi_hit) begin
            cmd.kind    = CMD_EOI;
            cnt_nxt     = cnt_r + 1'b1;
            cmd.frames  = cnt_nxt;
            len_nxt     = '0;
            prev_ff_nxt = 1'b0;
          end else begin
            len_nxt     = len_inc[LENGTH_BITS-1:0];
            prev_ff_nxt = is_ff;
          end
        end
      end
      default: begin
        len_nxt     = '0;
        prev_ff_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FR_HUNT;
      max_r     <= MAX_RESET;
      len_r     <= '0;
      prev_ff_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      len_r     <= len_nxt;
      prev_ff_r <= prev_ff_nxt;
      cnt_r     <= cnt_nxt;
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
    end
  end

  a_hunt_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FR_HUNT |-> len_r == '0)
    else $error("length not cleared while hunting");

  a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FR_FRAME |-> len_r >= LENGTH_BITS'(2))
    else $error("frame length below SOI size");

  a_eoi_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push && cmd.kind == CMD_EOI |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("frame count did not advance on EOI");

endmodule

// ===== design/fjd_back.sv =====
module fjd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fjd_pkg::cmd_t               head,
  input  fjd_pkg::q_stat_t            q_stat,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [7:0]                  out_byte,
  output logic                        out_frame_start,
  output logic                        out_frame_end,
  output logic                        out_frame_abort,
  output logic [fjd_pkg::FRAMES_W-1:0] out_frames_done,
  output logic                        out_run_last
);
  import fjd_pkg::*;

  back_state_t         state_r, state_nxt;
  logic                valid_r, valid_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic                start_r, start_nxt;
  logic                end_r, end_nxt;
  logic                abort_r, abort_nxt;
  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  logic                last_r, last_nxt;
  logic                load;

  // refill the output register when it is free or being taken
  assign load = !q_stat.empty && (!valid_r || pop);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_FIRST: begin
        if (load && head.kind == CMD_SOI) begin
          state_nxt = BK_SECOND;
        end
      end
      BK_SECOND: begin
        if (load) begin
          state_nxt = BK_FIRST;
        end
      end
      default: state_nxt = BK_FIRST;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    byte_nxt   = byte_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    abort_nxt  = abort_r;
    frames_nxt = frames_r;
    last_nxt   = last_r;
    valid_nxt  = valid_r && !pop;
    if (load) begin
      valid_nxt  = 1'b1;
      frames_nxt = head.frames;
      byte_nxt   = head.data;
      start_nxt  = 1'b0;
      end_nxt    = 1'b0;
      abort_nxt  = 1'b0;
      last_nxt   = 1'b1;
      q_pop      = 1'b1;
      case (state_r)
        BK_FIRST: begin
          case (head.kind)
            CMD_SOI: begin
              // hold the SOI entry for its second byte
              byte_nxt  = MARK_FF;
              start_nxt = 1'b1;
              last_nxt  = 1'b0;
              q_pop     = 1'b0;
            end
            CMD_EOI:   end_nxt = 1'b1;
            CMD_ABORT: begin
              abort_nxt = 1'b1;
              byte_nxt  = '0;
            end
            default: ;
          endcase
        end
        BK_SECOND: byte_nxt = MARK_SOI;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_FIRST;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    abort_r  <= abort_nxt;
    frames_r <= frames_nxt;
    last_r   <= last_nxt;
  end

  assign empty           = !valid_r;
  assign out_byte        = byte_r;
  assign out_frame_start = start_r;
  assign out_frame_end   = end_r;
  assign out_frame_abort = abort_r;
  assign out_frames_done = frames_r;
  assign out_run_last    = last_r;

  a_second_soi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SECOND |-> !q_stat.empty && head.kind == CMD_SOI)
    else $error("second SOI byte without SOI entry");

  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && start_r |-> !last_r && state_r == BK_SECOND)
    else $error("frame start byte marked last");

endmodule

// ===== design/jpeg_frame_delimiter_core.sv =====
// MJPEG frame delimiter: cuts a byte stream into frames bounded by SOI and EOI.
// Input queue side: drive in_byte and push; the byte is taken on a clock edge
// with push high and full low. Result queue side: while empty is low the
// oldest result sits on the out_ ports; pop with empty low takes it.
// Each result carries the byte (zero on an abort), start/end/abort flags, the
// completed frame count and run_last on the last result of an input byte.
// A byte inside a frame gives one result; the byte completing SOI gives two
// (FF then D8); bytes while hunting give none.
// A result passes the command queue and the output register before the ports.
// Throughput: one byte per cycle while full is low; the result stage
// emits one result per cycle while pop keeps up; the extra SOI result is
// absorbed by a FIFO_DEPTH command queue between classifier and result stage.
// If pop stays low the queue fills and full rises; nothing is lost.
// cfg_we/cfg_wdata set max_frame_bytes; write it only while idle.
// Reset (rst_n low, synchronous) empties both sides, restores the 1 MiB
// frame limit, clears the frame count and starts hunting.
module jpeg_frame_delimiter_core #(
  parameter int LENGTH_BITS = 24,
  parameter int FIFO_DEPTH  = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fjd_pkg::MAX_W-1:0]    cfg_wdata,
  input  logic                         push,
  output logic                         full,
  input  logic [7:0]                   in_byte,
  input  logic                         pop,
  output logic                         empty,
  output logic [7:0]                   out_byte,
  output logic                         out_frame_start,
  output logic                         out_frame_end,
  output logic                         out_frame_abort,
  output logic [fjd_pkg::FRAMES_W-1:0] out_frames_done,
  output logic                         out_run_last
);
  import fjd_pkg::*;

  cmd_t    cmd, head;
  logic    cmd_push, q_pop;
  q_stat_t q_stat;

  assign full = q_stat.full;

  fjd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .in_byte  (in_byte),
    .q_full   (q_stat.full),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  fjd_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_push),
    .wr_data(cmd),
    .rd_en  (q_pop),
    .rd_data(head),
    .stat   (q_stat)
  );

  fjd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_frame_start(out_frame_start),
    .out_frame_end  (out_frame_end),
    .out_frame_abort(out_frame_abort),
    .out_frames_done(out_frames_done),
    .out_run_last   (out_run_last)
  );

  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_frame_abort |-> out_byte == 8'h00 && out_run_last)
    else $error("abort result carries data");

endmodule
